/* rtl/bvr_pkg.sv */
`timescale 1ns / 1ps
// bvr_pkg: widths, segment codes and per-segment coefficients for the B-V to RGB pipe.
// No dependencies; imported by every bvr_* module and the top level.
package bvr_pkg;

  localparam int FRACTION_BITS = 10;
  localparam int UNIT          = 1 << FRACTION_BITS;

  localparam int IDX_W = 16;                        // input index width
  localparam int CH_W  = 11;                        // output channel width
  localparam int N_W   = IDX_W + 7;                 // index scaled by 100
  localparam int U_W   = $clog2(120 * UNIT);        // offset inside a segment
  localparam int SQ_W  = 2 * U_W;
  localparam int T_W   = 32;                        // scaled numerator
  localparam int LIN_W = T_W;
  localparam int BK_W  = 14;
  localparam int C_W   = 8;
  localparam int CQ_W  = SQ_W + C_W;
  localparam int D_W   = 21;
  localparam int M_W   = 26;
  localparam int Q_W   = 12;
  localparam int REM_W = D_W + 1;
  localparam int RECIP_SHIFT = T_W - 1;
  localparam int PROD_W = RECIP_SHIFT + M_W;

  localparam int NUM_STG = 8;

  localparam logic signed [N_W-1:0] SCALE  = N_W'(100);
  localparam logic signed [N_W-1:0] TH_N40 = N_W'(-40 * UNIT);
  localparam logic signed [N_W-1:0] TH_0   = N_W'(0);
  localparam logic signed [N_W-1:0] TH_40  = N_W'(40 * UNIT);
  localparam logic signed [N_W-1:0] TH_150 = N_W'(150 * UNIT);
  localparam logic signed [N_W-1:0] TH_160 = N_W'(160 * UNIT);
  localparam logic signed [N_W-1:0] TH_194 = N_W'(194 * UNIT);
  localparam logic signed [N_W-1:0] TH_200 = N_W'(200 * UNIT);

  localparam int D2_K1   = 100;
  localparam int D2_K40  = 100 * 40 * 40;
  localparam int D2_K44  = 100 * 44 * 44;
  localparam int D2_K110 = 100 * 110 * 110;
  localparam int D2_K120 = 100 * 120 * 120;

  localparam logic [M_W-1:0] M_K1   = M_W'((64'd1 << RECIP_SHIFT) / D2_K1);
  localparam logic [M_W-1:0] M_K40  = M_W'((64'd1 << RECIP_SHIFT) / D2_K40);
  localparam logic [M_W-1:0] M_K44  = M_W'((64'd1 << RECIP_SHIFT) / D2_K44);
  localparam logic [M_W-1:0] M_K110 = M_W'((64'd1 << RECIP_SHIFT) / D2_K110);
  localparam logic [M_W-1:0] M_K120 = M_W'((64'd1 << RECIP_SHIFT) / D2_K120);

  typedef enum logic [3:0] {
    SEG_R_LO,
    SEG_R_MID,
    SEG_R_HI,
    SEG_G_LO,
    SEG_G_MID,
    SEG_G_FALL,
    SEG_G_RED,
    SEG_G_ZERO,
    SEG_B_FLAT,
    SEG_B_FALL,
    SEG_B_RED,
    SEG_B_ZERO
  } seg_t;

  typedef struct packed {
    seg_t           code;
    logic [U_W-1:0] u;
  } chan_seg_t;

  typedef struct packed {
    seg_t                  code;
    logic signed [T_W-1:0] t1;
  } chan_t;

  typedef struct packed {
    logic signed [T_W-1:0]  k0;
    logic signed [BK_W-1:0] bk;
    logic signed [C_W-1:0]  c;
    logic [D_W-1:0]         d2;
    logic [M_W-1:0]         m;
  } coef_t;

  // k0 folds the constant term and the rounding half into numerator / UNIT
  function automatic coef_t mk_coef(int a, int b, int c, int k, logic [M_W-1:0] m);
    coef_t cf;
    cf.k0 = T_W'((a * UNIT + 50) * k * k);
    cf.bk = BK_W'(b * k);
    cf.c  = C_W'(c);
    cf.d2 = D_W'(100 * k * k);
    cf.m  = m;
    return cf;
  endfunction

  function automatic coef_t seg_coef(seg_t s);
    coef_t cf;
    case (s)
      SEG_R_LO:   cf = mk_coef(61, 11, 10, 40, M_K40);
      SEG_R_MID:  cf = mk_coef(83, 17, 0, 40, M_K40);
      SEG_R_HI:   cf = mk_coef(100, 0, 0, 1, M_K1);
      SEG_G_LO:   cf = mk_coef(70, 7, 10, 40, M_K40);
      SEG_G_MID:  cf = mk_coef(87, 11, 0, 40, M_K40);
      SEG_G_FALL: cf = mk_coef(98, -16, 0, 120, M_K120);
      SEG_G_RED:  cf = mk_coef(82, 0, -50, 40, M_K40);
      SEG_B_FLAT: cf = mk_coef(100, 0, 0, 1, M_K1);
      SEG_B_FALL: cf = mk_coef(100, -47, 10, 110, M_K110);
      SEG_B_RED:  cf = mk_coef(63, 0, -60, 44, M_K44);
      default:    cf = mk_coef(0, 0, 0, 1, M_K1);
    endcase
    return cf;
  endfunction

endpackage

/* rtl/bvr_seg.sv */
`timescale 1ns / 1ps
// bvr_seg: two stages - scale and clamp the index, then pick each channel's segment.
// Depends on bvr_pkg.
module bvr_seg (
  input  logic                               clk,
  input  logic [1:0]                         en,
  input  logic signed [bvr_pkg::IDX_W-1:0]   color_index,
  output bvr_pkg::chan_seg_t                 r_seg_r,
  output bvr_pkg::chan_seg_t                 g_seg_r,
  output bvr_pkg::chan_seg_t                 b_seg_r
);
  import bvr_pkg::*;

  logic signed [N_W-1:0] x_ext;
  logic signed [N_W-1:0] n_full;
  logic signed [N_W-1:0] n_nxt;
  logic signed [N_W-1:0] n_r;
  logic signed [N_W-1:0] r_du;
  logic signed [N_W-1:0] g_du;
  logic signed [N_W-1:0] b_du;
  chan_seg_t             r_seg_nxt;
  chan_seg_t             g_seg_nxt;
  chan_seg_t             b_seg_nxt;

  always_comb begin
    x_ext  = N_W'(color_index);
    n_full = x_ext * SCALE;
    if (n_full < TH_N40) begin
      n_nxt = TH_N40;
    end else if (n_full > TH_200) begin
      n_nxt = TH_200;
    end else begin
      n_nxt = n_full;
    end
  end

  always_comb begin
    if (n_r < TH_0) begin
      r_seg_nxt.code = SEG_R_LO;
      r_du           = n_r - TH_N40;
    end else if (n_r < TH_40) begin
      r_seg_nxt.code = SEG_R_MID;
      r_du           = n_r;
    end else begin
      r_seg_nxt.code = SEG_R_HI;
      r_du           = TH_0;
    end
    r_seg_nxt.u = U_W'(r_du);

    if (n_r < TH_0) begin
      g_seg_nxt.code = SEG_G_LO;
      g_du           = n_r - TH_N40;
    end else if (n_r < TH_40) begin
      g_seg_nxt.code = SEG_G_MID;
      g_du           = n_r;
    end else if (n_r < TH_160) begin
      g_seg_nxt.code = SEG_G_FALL;
      g_du           = n_r - TH_40;
    end else if (n_r < TH_200) begin
      g_seg_nxt.code = SEG_G_RED;
      g_du           = n_r - TH_160;
    end else begin
      g_seg_nxt.code = SEG_G_ZERO;
      g_du           = TH_0;
    end
    g_seg_nxt.u = U_W'(g_du);

    if (n_r < TH_40) begin
      b_seg_nxt.code = SEG_B_FLAT;
      b_du           = TH_0;
    end else if (n_r < TH_150) begin
      b_seg_nxt.code = SEG_B_FALL;
      b_du           = n_r - TH_40;
    end else if (n_r < TH_194) begin
      b_seg_nxt.code = SEG_B_RED;
      b_du           = n_r - TH_150;
    end else begin
      b_seg_nxt.code = SEG_B_ZERO;
      b_du           = TH_0;
    end
    b_seg_nxt.u = U_W'(b_du);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_r <= n_nxt;
    end
    if (en[1]) begin
      r_seg_r <= r_seg_nxt;
      g_seg_r <= g_seg_nxt;
      b_seg_r <= b_seg_nxt;
    end
  end

endmodule

/* rtl/bvr_poly.sv */
`timescale 1ns / 1ps
// bvr_poly: three stages evaluating one channel's segment polynomial, scaled by 1/UNIT.
// Depends on bvr_pkg.
module bvr_poly (
  input  logic               clk,
  input  logic [2:0]         en,
  input  bvr_pkg::chan_seg_t seg_in,
  output bvr_pkg::chan_t     t_out_r
);
  import bvr_pkg::*;

  coef_t                   cf3;
  coef_t                   cf4;
  logic [SQ_W-1:0]         sq_nxt;
  logic [SQ_W-1:0]         sq_r;
  logic signed [LIN_W-1:0] lin_nxt;
  logic signed [LIN_W-1:0] lin_r;
  seg_t                    code3_r;
  logic signed [CQ_W-1:0]  cq_full;
  logic signed [T_W-1:0]   cq_nxt;
  logic signed [T_W-1:0]   cq_r;
  logic signed [T_W-1:0]   sum_nxt;
  logic signed [T_W-1:0]   sum_r;
  seg_t                    code4_r;
  chan_t                   t_out_nxt;

  always_comb begin
    cf3     = seg_coef(seg_in.code);
    sq_nxt  = SQ_W'(seg_in.u) * SQ_W'(seg_in.u);
    lin_nxt = LIN_W'(cf3.bk) * $signed(LIN_W'(seg_in.u));
  end

  // floor(c * u^2 / UNIT); the other terms are already whole
  always_comb begin
    cf4     = seg_coef(code3_r);
    cq_full = CQ_W'(cf4.c) * $signed(CQ_W'(sq_r));
    cq_nxt  = T_W'(cq_full >>> FRACTION_BITS);
    sum_nxt = cf4.k0 + T_W'(lin_r);
  end

  always_comb begin
    t_out_nxt.code = code4_r;
    t_out_nxt.t1   = sum_r + cq_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_r    <= sq_nxt;
      lin_r   <= lin_nxt;
      code3_r <= seg_in.code;
    end
    if (en[1]) begin
      cq_r    <= cq_nxt;
      sum_r   <= sum_nxt;
      code4_r <= code3_r;
    end
    if (en[2]) begin
      t_out_r <= t_out_nxt;
    end
  end

endmodule

/* rtl/bvr_div.sv */
`timescale 1ns / 1ps
// bvr_div: three stages dividing by the segment's constant via reciprocal multiply,
// correcting the quotient and saturating. Depends on bvr_pkg.
module bvr_div (
  input  logic                      clk,
  input  logic [2:0]                en,
  input  bvr_pkg::chan_t            t_in,
  output logic [bvr_pkg::CH_W-1:0]  val_r
);
  import bvr_pkg::*;

  coef_t              cf6;
  coef_t              cf7;
  coef_t              cf8;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     qe_nxt;
  logic [Q_W-1:0]     qe6_r;
  logic [T_W-2:0]     t6_r;
  seg_t               code6_r;
  logic               neg_nxt;
  logic               neg6_r;
  logic [T_W-1:0]     qd;
  logic [T_W-1:0]     diff;
  logic [REM_W-1:0]   rem_nxt;
  logic [REM_W-1:0]   rem7_r;
  logic [Q_W-1:0]     qe7_r;
  seg_t               code7_r;
  logic               neg7_r;
  logic [Q_W-1:0]     q;
  logic [CH_W-1:0]    val_nxt;

  // estimate is exact or one low
  always_comb begin
    cf6     = seg_coef(t_in.code);
    neg_nxt = t_in.t1[T_W-1];
    prod    = PROD_W'(t_in.t1[T_W-2:0]) * PROD_W'(cf6.m);
    qe_nxt  = prod[RECIP_SHIFT +: Q_W];
  end

  always_comb begin
    cf7     = seg_coef(code6_r);
    qd      = T_W'(qe6_r) * T_W'(cf7.d2);
    diff    = T_W'(t6_r) - qd;
    rem_nxt = diff[REM_W-1:0];
  end

  always_comb begin
    cf8 = seg_coef(code7_r);
    q   = qe7_r + Q_W'(rem7_r >= REM_W'(cf8.d2));
    if (neg7_r) begin
      val_nxt = '0;
    end else if (q > Q_W'(UNIT)) begin
      val_nxt = CH_W'(UNIT);
    end else begin
      val_nxt = CH_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      qe6_r   <= qe_nxt;
      t6_r    <= t_in.t1[T_W-2:0];
      code6_r <= t_in.code;
      neg6_r  <= neg_nxt;
    end
    if (en[1]) begin
      rem7_r  <= rem_nxt;
      qe7_r   <= qe6_r;
      code7_r <= code6_r;
      neg7_r  <= neg6_r;
    end
    if (en[2]) begin
      val_r <= val_nxt;
    end
  end

endmodule

/* rtl/bv_index_to_rgb.sv */
`timescale 1ns / 1ps
// bv_index_to_rgb: star color index (B-V) to RGB intensity, top level.
// Depends on bvr_pkg, bvr_seg, bvr_poly and bvr_div.
//
// Usage:
//   Input channel in_valid / in_stall carries one signed B-V index per
//   transaction (in_color_index, 10 fraction bits). The result channel
//   out_valid / out_stall carries out_red, out_green, out_blue, each 0..1024
//   with 1024 meaning 1.0.
//   The datapath is an 8-stage pipeline: clamp/scale, segment select,
//   square and linear products, quadratic scaling, sum, reciprocal multiply,
//   remainder, correct and saturate. A result appears on out_valid from the
//   last stage, and one transaction per cycle is sustained while out_stall
//   is low. The polynomial and the constant divider each hold two multiplier
//   stages per channel.
//   Each stage holds its own valid bit; a stage loads when it is empty or
//   the stage after it moves, so bubbles close up while out_stall is high
//   and in_stall only rises once every stage holds a transaction.
//   A stalled result holds steady on the output register.
//   Reset (rst_n low, synchronous) clears all valid bits; no data is lost or
//   duplicated across stalls.
module bv_index_to_rgb (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [bvr_pkg::IDX_W-1:0]  in_color_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bvr_pkg::CH_W-1:0]          out_red,
  output logic [bvr_pkg::CH_W-1:0]          out_green,
  output logic [bvr_pkg::CH_W-1:0]          out_blue
);
  import bvr_pkg::*;

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] vld_in;
  logic [NUM_STG-1:0] rdy;
  chan_seg_t          r_seg;
  chan_seg_t          g_seg;
  chan_seg_t          b_seg;
  chan_t              r_t;
  chan_t              g_t;
  chan_t              b_t;

  always_comb begin
    rdy[NUM_STG-1] = !vld_r[NUM_STG-1] || !out_stall;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_in  = {vld_r[NUM_STG-2:0], in_valid};
    vld_nxt = (rdy & vld_in) | (~rdy & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NUM_STG-1];

  bvr_seg u_seg (
    .clk         (clk),
    .en          (rdy[1:0]),
    .color_index (in_color_index),
    .r_seg_r     (r_seg),
    .g_seg_r     (g_seg),
    .b_seg_r     (b_seg)
  );

  bvr_poly u_poly_r (.clk(clk), .en(rdy[4:2]), .seg_in(r_seg), .t_out_r(r_t));
  bvr_poly u_poly_g (.clk(clk), .en(rdy[4:2]), .seg_in(g_seg), .t_out_r(g_t));
  bvr_poly u_poly_b (.clk(clk), .en(rdy[4:2]), .seg_in(b_seg), .t_out_r(b_t));

  bvr_div u_div_r (.clk(clk), .en(rdy[7:5]), .t_in(r_t), .val_r(out_red));
  bvr_div u_div_g (.clk(clk), .en(rdy[7:5]), .t_in(g_t), .val_r(out_green));
  bvr_div u_div_b (.clk(clk), .en(rdy[7:5]), .t_in(b_t), .val_r(out_blue));

endmodule

/* rtl/bvr_check.sv */
`timescale 1ns / 1ps
// bvr_check: port-level assertions for bv_index_to_rgb, bound to the top level.
// Depends on bvr_pkg.
module bvr_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bvr_pkg::CH_W-1:0]    out_red,
  input logic [bvr_pkg::CH_W-1:0]    out_green,
  input logic [bvr_pkg::CH_W-1:0]    out_blue
);
  import bvr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red <= CH_W'(UNIT) && out_green <= CH_W'(UNIT)
      && out_blue <= CH_W'(UNIT))
    else $error("channel above full scale");

  a_no_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_green_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_green == '0 |-> out_blue == '0)
    else $error("green zero without blue zero");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid result after reset");

endmodule

bind bv_index_to_rgb bvr_check u_bvr_check (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for bv_index_to_rgb, the B-V index to RGB pipe.
// Depends on bvr_pkg and the RTL; it checks every result against a built-in predictor.
module testbench;

  import bvr_pkg::*;

  localparam longint ONE_UNIT   = longint'(1) << FRACTION_BITS;
  localparam int     CYCLE_CAP  = 200000;
  localparam int     HOLD_LEN   = 250;
  localparam int     SETTLE_LEN = 20;

  typedef struct {
    logic signed [IDX_W-1:0] idx;
    logic [CH_W-1:0]         red;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         blue;
  } rgb_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [IDX_W-1:0] in_color_index;
  logic                    out_valid;
  logic                    out_stall;
  logic [CH_W-1:0]         out_red;
  logic [CH_W-1:0]         out_green;
  logic [CH_W-1:0]         out_blue;

  rgb_t pending_rgb[$];
  int   mismatch_count;
  int   checked_count;
  int   cycle_count;
  int   long_hold_cycles;
  bit   tx_gaps_on;
  bit   rx_gaps_on;

  bv_index_to_rgb dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_color_index (in_color_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // round(UNIT * (a + b*t + c*t^2) / 100), t = u / (k * UNIT), saturated to 0..UNIT
  function automatic logic [CH_W-1:0] curve_point(longint a, longint b, longint c,
                                                  longint u, longint k);
    longint kd;
    longint num;
    longint den;
    longint q;
    kd  = k * ONE_UNIT;
    num = a * kd * kd + b * u * kd + c * u * u;
    den = 100 * k * k * ONE_UNIT;
    if (num <= 0) return '0;
    q = (num * 2 + den) / (den * 2);
    if (q > ONE_UNIT) q = ONE_UNIT;
    return q[CH_W-1:0];
  endfunction

  function automatic rgb_t predict_rgb(logic signed [IDX_W-1:0] idx);
    rgb_t   res;
    longint n;
    res.idx = idx;
    n = 100 * longint'(idx);
    if (n < -40 * ONE_UNIT) n = -40 * ONE_UNIT;
    if (n > 200 * ONE_UNIT) n = 200 * ONE_UNIT;

    if (n < 0)                   res.red = curve_point(61, 11, 10, n + 40 * ONE_UNIT, 40);
    else if (n < 40 * ONE_UNIT)  res.red = curve_point(83, 17, 0, n, 40);
    else                         res.red = curve_point(100, 0, 0, 0, 1);

    if (n < 0)                   res.green = curve_point(70, 7, 10, n + 40 * ONE_UNIT, 40);
    else if (n < 40 * ONE_UNIT)  res.green = curve_point(87, 11, 0, n, 40);
    else if (n < 160 * ONE_UNIT) res.green = curve_point(98, -16, 0, n - 40 * ONE_UNIT, 120);
    else if (n < 200 * ONE_UNIT) res.green = curve_point(82, 0, -50, n - 160 * ONE_UNIT, 40);
    else                         res.green = '0;

    if (n < 40 * ONE_UNIT)       res.blue = curve_point(100, 0, 0, 0, 1);
    else if (n < 150 * ONE_UNIT) res.blue = curve_point(100, -47, 10, n - 40 * ONE_UNIT, 110);
    else if (n < 194 * ONE_UNIT) res.blue = curve_point(63, 0, -60, n - 150 * ONE_UNIT, 44);
    else                         res.blue = '0;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // result check first, then record the transaction accepted at the same edge
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        flag_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                out_red, out_green, out_blue));
      end else begin
        want = pending_rgb.pop_front();
        checked_count++;
        if (out_red !== want.red)
          flag_mismatch($sformatf("idx=%0d red got %0d want %0d", want.idx, out_red, want.red));
        if (out_green !== want.green)
          flag_mismatch($sformatf("idx=%0d green got %0d want %0d",
                                  want.idx, out_green, want.green));
        if (out_blue !== want.blue)
          flag_mismatch($sformatf("idx=%0d blue got %0d want %0d",
                                  want.idx, out_blue, want.blue));
      end
    end
    if (rst_n && in_valid && !in_stall) pending_rgb.push_back(predict_rgb(in_color_index));
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_rgb.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver: random stall before each result while rx gaps are on, or one long hold on request
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_cycles > 0) n = long_hold_cycles;
      else n = rx_gaps_on ? $urandom_range(0, 12) : 0;
      long_hold_cycles = 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // returns at the edge that accepted the transaction
  task automatic send_index(input logic signed [IDX_W-1:0] idx);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_color_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic signed [IDX_W-1:0] edges[$];
    edges = '{-16'sd32768, 16'sd32767, -16'sd32767, -16'sd411, -16'sd410, -16'sd409, -16'sd1,
              16'sd0, 16'sd1, 16'sd409, 16'sd410, 16'sd1024, 16'sd1535, 16'sd1536,
              16'sd1638, 16'sd1639, 16'sd1986, 16'sd1987, 16'sd2047, 16'sd2048, 16'sd2049};
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    foreach (edges[i]) send_index(edges[i]);
    wait_drained();
  endtask

  task automatic test_segment_sweep();
    int v;
    for (int i = 0; i < 300; i++) begin
      v = $urandom_range(0, 2700);
      send_index(IDX_W'(v - 500));
    end
  endtask

  task automatic test_full_range();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    for (int i = 0; i < 150; i++) send_index(IDX_W'($urandom));
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_drained();
    long_hold_cycles = HOLD_LEN;
    tx_gaps_on = 1'b0;
    for (int i = 0; i < 40; i++) send_index(IDX_W'($urandom_range(0, 2600)) - 16'sd400);
    tx_gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_mixed();
    int pick;
    int v;
    logic signed [IDX_W-1:0] knees[$];
    knees = '{-16'sd410, 16'sd0, 16'sd410, 16'sd1536, 16'sd1638, 16'sd1987, 16'sd2048};
    for (int i = 0; i < 160; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) v = $urandom_range(0, 2800) - 600;
      else if (pick < 9) v = knees[$urandom_range(0, knees.size() - 1)] +
                             $urandom_range(0, 8) - 4;
      else v = $urandom;
      send_index(IDX_W'(v));
    end
    wait_drained();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_color_index   <= '0;
    mismatch_count   = 0;
    checked_count    = 0;
    cycle_count      = 0;
    long_hold_cycles = 0;
    tx_gaps_on       = 1'b1;
    rx_gaps_on       = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_segment_sweep();
    test_full_range();
    test_backpressure();
    test_mixed();

    repeat (SETTLE_LEN) @(posedge clk);
    if (pending_rgb.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_rgb.size()));
    $display("summary: %0d color indices checked (range clamps, segment knees,", checked_count);
    $display("summary: full 16-bit sweep, random idling and a %0d-cycle output hold)", HOLD_LEN);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bvr_pkg.sv
rtl/bvr_seg.sv
rtl/bvr_poly.sv
rtl/bvr_div.sv
rtl/bv_index_to_rgb.sv
rtl/bvr_check.sv
dv/testbench.sv
